// ===== design/limit_order_book_matcher_unit_defines.svh =====
// ============================================================================
// Limit order book matcher assertion macros
// Shared property wrappers for the checker of the matcher unit.
// ============================================================================
`ifndef LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH
`define LIMIT_ORDER_BOOK_MATCHER_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LOBM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LOBM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lobm_pkg.sv =====
// ============================================================================
// Limit order book matcher package
// Command and status codes shared by the matcher and its checker.
// ============================================================================
package lobm_pkg;

  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_MODIFY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_BAD_QTY = 2'd3;

endpackage

// ===== design/lobm_ram.sv =====
// ============================================================================
// Generic RAM
// One write port and one read port, read data registered.
// ============================================================================
module lobm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/limit_order_book_matcher_unit.sv =====
// ============================================================================
// Limit order book matcher
// Price-time priority order book with matching, cancel and modify.
// ============================================================================
// A command is taken when start is high and busy is low; busy stays high until
// the last result beat of that command has been shown. Results come out one
// beat per cycle on out_strobe and cannot be held off. A command gives one beat
// per fill, oldest resting order first, or a single status beat when it fills
// nothing; out_last marks the final beat, and every beat carries the best bid
// and best ask as they stand after the whole command. The fills of a command
// are collected in a result RAM and played out once the book has settled, so
// the best prices can be attached. Orders live in an order RAM (linked per
// level) and levels in a level RAM (occupied bit, head, tail), each with
// registered read data. A plain rest reads the level and writes the order,
// then links it behind the old tail if the level held orders; each fill reads
// the level head and its order, and unlinks the resting order when it takes
// it out. When a level empties at the best price, the best price of that side
// is found again by a walk over every slot of the order RAM. After reset a
// clearing pass writes all 2 * 2^ceil(log2(PRICE_TICKS)) entries of the level
// RAM (512 at the default), during which busy is high.
// ============================================================================
module limit_order_book_matcher_unit
  import lobm_pkg::*;
#(
  parameter int ORDER_SLOTS = 64,
  parameter int PRICE_TICKS = 256,
  parameter int QTY_BITS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_cmd,
  input  logic [5:0]  in_order_id,
  input  logic        in_side,
  input  logic [7:0]  in_price,
  input  logic [15:0] in_quantity,
  output logic        out_strobe,
  output logic        out_is_trade,
  output logic [5:0]  out_taker_id,
  output logic [5:0]  out_maker_id,
  output logic [7:0]  out_trade_price,
  output logic [15:0] out_fill_qty,
  output logic        out_taker_side,
  output logic [1:0]  out_status,
  output logic        out_last,
  output logic        out_bid_valid,
  output logic [7:0]  out_bid_price,
  output logic        out_ask_valid,
  output logic [7:0]  out_ask_price
);

  localparam int ID_W   = $clog2(ORDER_SLOTS);
  localparam int PX_W   = $clog2(PRICE_TICKS);
  localparam int LVL_AW = PX_W + 1;
  localparam int LVL_DEPTH = 2 ** LVL_AW;
  localparam int CNT_W  = ID_W + 1;

  // One order: its level, remaining quantity and its links within the level.
  typedef struct packed {
    logic                side;
    logic [PX_W-1:0]     px;
    logic [QTY_BITS-1:0] qty;
    logic [ID_W-1:0]     nxt;
    logic [ID_W-1:0]     prv;
    logic                has_nxt;
    logic                has_prv;
  } ord_t;

  // One price level of one side: occupied flag and queue ends.
  typedef struct packed {
    logic            occ;
    logic [ID_W-1:0] head;
    logic [ID_W-1:0] tail;
  } lvl_t;

  // One buffered fill, played out after the command completes.
  typedef struct packed {
    logic [ID_W-1:0]     maker;
    logic [PX_W-1:0]     px;
    logic [QTY_BITS-1:0] qty;
  } fill_t;

  localparam int ORD_W  = $bits(ord_t);
  localparam int LVL_W  = $bits(lvl_t);
  localparam int FILL_W = $bits(fill_t);

  typedef enum logic [16:0] {
    S_CLR    = 17'b00000000000000001,
    S_IDLE   = 17'b00000000000000010,
    S_LD     = 17'b00000000000000100,
    S_ADD    = 17'b00000000000001000,
    S_M_HD   = 17'b00000000000010000,
    S_M_OR   = 17'b00000000000100000,
    S_R_LV   = 17'b00000000001000000,
    S_R_TL   = 17'b00000000010000000,
    S_UL_RD  = 17'b00000000100000000,
    S_UL_LV  = 17'b00000001000000000,
    S_UL_PV  = 17'b00000010000000000,
    S_UL_NX  = 17'b00000100000000000,
    S_UL_FIN = 17'b00001000000000000,
    S_SCAN   = 17'b00010000000000000,
    S_DONE   = 17'b00100000000000000,
    S_EMIT   = 17'b01000000000000000,
    S_STAT   = 17'b10000000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Command being worked on.
  logic [1:0]          cmd_r, cmd_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic                side_r, side_nxt;
  logic [PX_W-1:0]     px_r, px_nxt;
  logic [QTY_BITS-1:0] qty_r, qty_nxt;
  logic [1:0]          status_r, status_nxt;
  logic [CNT_W-1:0]    nfill_r, nfill_nxt;

  // Unlink context and a scratch order index.
  ord_t                ent_r, ent_nxt;
  logic [ID_W-1:0]     ul_id_r, ul_id_nxt;
  logic [ID_W-1:0]     head_r, head_nxt;
  logic                empt_r, empt_nxt;

  // Book summary.
  logic [ORDER_SLOTS-1:0] valid_r, valid_nxt;
  logic                bid_ok_r, bid_ok_nxt;
  logic [PX_W-1:0]     bid_px_r, bid_px_nxt;
  logic                ask_ok_r, ask_ok_nxt;
  logic [PX_W-1:0]     ask_px_r, ask_px_nxt;

  // Clearing pass, best price walk and playout counters.
  logic [LVL_AW-1:0]   clr_r, clr_nxt;
  logic [CNT_W-1:0]    sc_k_r, sc_k_nxt;
  logic                sc_pend_r, sc_pend_nxt;
  logic [ID_W-1:0]     sc_idx_r, sc_idx_nxt;
  logic                sc_found_r, sc_found_nxt;
  logic [PX_W-1:0]     sc_px_r, sc_px_nxt;
  logic                sc_side_r, sc_side_nxt;
  logic [CNT_W-1:0]    em_k_r, em_k_nxt;
  logic                em_pend_r, em_pend_nxt;

  // Memory ports.
  logic              o_we, o_re;
  logic [ID_W-1:0]   o_waddr, o_raddr;
  ord_t              o_wr;
  logic [ORD_W-1:0]  o_rdata;
  ord_t              o_ent;
  logic              l_we, l_re;
  logic [LVL_AW-1:0] l_waddr, l_raddr;
  lvl_t              l_wr;
  logic [LVL_W-1:0]  l_rdata;
  lvl_t              l_ent;
  logic              f_we, f_re;
  logic [ID_W-1:0]   f_waddr, f_raddr;
  fill_t             f_wr;
  logic [FILL_W-1:0] f_rdata;
  fill_t             f_ent;

  assign o_ent = ord_t'(o_rdata);
  assign l_ent = lvl_t'(l_rdata);
  assign f_ent = fill_t'(f_rdata);

  // Input decode helpers.
  logic [12:0]         px_wide;
  logic [PX_W-1:0]     px_in;
  logic [QTY_BITS-1:0] qty_in;
  logic [ID_W-1:0]     idx_in;
  logic                id_oob;

  assign px_wide = 13'(in_price);
  assign px_in   = (px_wide >= 13'(PRICE_TICKS)) ? PX_W'(PRICE_TICKS - 1) : PX_W'(in_price);
  assign qty_in  = QTY_BITS'(in_quantity);
  assign idx_in  = ID_W'(in_order_id);
  assign id_oob  = ({1'b0, in_order_id} >= 7'(ORDER_SLOTS));

  // Matching helpers.
  logic                crosses;
  logic [PX_W-1:0]     opp_px;
  logic [QTY_BITS-1:0] fill_q;
  logic                scan_hit;
  logic                was_best;

  assign crosses = side_r ? (bid_ok_r && (px_r <= bid_px_r))
                          : (ask_ok_r && (px_r >= ask_px_r));
  assign opp_px  = side_r ? bid_px_r : ask_px_r;
  assign fill_q  = (qty_r < o_ent.qty) ? qty_r : o_ent.qty;
  assign scan_hit = valid_r[sc_idx_r] && (o_ent.side == sc_side_r) &&
                    (!sc_found_r || (sc_side_r ? (o_ent.px < sc_px_r)
                                               : (o_ent.px > sc_px_r)));
  assign was_best = ent_r.side ? (ent_r.px == ask_px_r) : (ent_r.px == bid_px_r);

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    id_nxt      = id_r;
    side_nxt    = side_r;
    px_nxt      = px_r;
    qty_nxt     = qty_r;
    status_nxt  = status_r;
    nfill_nxt   = nfill_r;
    ent_nxt     = ent_r;
    ul_id_nxt   = ul_id_r;
    head_nxt    = head_r;
    empt_nxt    = empt_r;
    valid_nxt   = valid_r;
    bid_ok_nxt  = bid_ok_r;
    bid_px_nxt  = bid_px_r;
    ask_ok_nxt  = ask_ok_r;
    ask_px_nxt  = ask_px_r;
    clr_nxt     = clr_r;
    sc_k_nxt    = sc_k_r;
    sc_pend_nxt = sc_pend_r;
    sc_idx_nxt  = sc_idx_r;
    sc_found_nxt = sc_found_r;
    sc_px_nxt   = sc_px_r;
    sc_side_nxt = sc_side_r;
    em_k_nxt    = em_k_r;
    em_pend_nxt = em_pend_r;

    o_we = 1'b0; o_waddr = '0; o_wr = o_ent;
    o_re = 1'b0; o_raddr = '0;
    l_we = 1'b0; l_waddr = '0; l_wr = l_ent;
    l_re = 1'b0; l_raddr = '0;
    f_we = 1'b0; f_waddr = '0; f_wr = '0;
    f_re = 1'b0; f_raddr = '0;

    unique case (state_r)
      S_CLR: begin
        l_we    = 1'b1;
        l_waddr = clr_r;
        l_wr    = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == {LVL_AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          cmd_nxt    = in_cmd;
          id_nxt     = idx_in;
          side_nxt   = in_side;
          px_nxt     = px_in;
          qty_nxt    = qty_in;
          status_nxt = ST_OK;
          nfill_nxt  = '0;
          if (id_oob) begin
            status_nxt = ST_UNKNOWN;
            state_nxt  = S_STAT;
          end else begin
            case (in_cmd)
              CMD_ADD: begin
                if (valid_r[idx_in]) begin
                  status_nxt = ST_DUP;
                  state_nxt  = S_STAT;
                end else begin
                  state_nxt = S_ADD;
                end
              end
              CMD_CANCEL: begin
                if (!valid_r[idx_in]) begin
                  status_nxt = ST_UNKNOWN;
                  state_nxt  = S_STAT;
                end else begin
                  o_re      = 1'b1;
                  o_raddr   = idx_in;
                  state_nxt = S_LD;
                end
              end
              CMD_MODIFY: begin
                if (qty_in == '0) begin
                  status_nxt = ST_BAD_QTY;
                  state_nxt  = S_STAT;
                end else if (!valid_r[idx_in]) begin
                  status_nxt = ST_UNKNOWN;
                  state_nxt  = S_STAT;
                end else begin
                  o_re      = 1'b1;
                  o_raddr   = idx_in;
                  state_nxt = S_LD;
                end
              end
              default: begin
                state_nxt = S_STAT;
              end
            endcase
          end
        end
      end

      S_LD: begin
        ent_nxt   = o_ent;
        ul_id_nxt = id_r;
        if (cmd_r == CMD_CANCEL) begin
          state_nxt = S_UL_RD;
        end else if ((qty_r > o_ent.qty) || (px_r != o_ent.px)) begin
          // Loses priority: pull it out, then add it again on its own side.
          side_nxt  = o_ent.side;
          state_nxt = S_UL_RD;
        end else begin
          o_we      = 1'b1;
          o_waddr   = id_r;
          o_wr      = o_ent;
          o_wr.qty  = qty_r;
          state_nxt = S_DONE;
        end
      end

      S_ADD: begin
        if ((qty_r != '0) && crosses) begin
          l_re      = 1'b1;
          l_raddr   = {~side_r, opp_px};
          state_nxt = S_M_HD;
        end else if (qty_r != '0) begin
          l_re      = 1'b1;
          l_raddr   = {side_r, px_r};
          state_nxt = S_R_LV;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_M_HD: begin
        head_nxt  = l_ent.head;
        o_re      = 1'b1;
        o_raddr   = l_ent.head;
        state_nxt = S_M_OR;
      end

      S_M_OR: begin
        f_we      = 1'b1;
        f_waddr   = nfill_r[ID_W-1:0];
        f_wr      = '{maker: head_r, px: o_ent.px, qty: fill_q};
        nfill_nxt = nfill_r + 1'b1;
        qty_nxt   = qty_r - fill_q;
        if (fill_q == o_ent.qty) begin
          ent_nxt   = o_ent;
          ul_id_nxt = head_r;
          state_nxt = S_UL_RD;
        end else begin
          o_we      = 1'b1;
          o_waddr   = head_r;
          o_wr      = o_ent;
          o_wr.qty  = o_ent.qty - fill_q;
          state_nxt = S_DONE;
        end
      end

      S_R_LV: begin
        o_we    = 1'b1;
        o_waddr = id_r;
        o_wr    = '{side: side_r, px: px_r, qty: qty_r, nxt: '0, prv: l_ent.tail,
                    has_nxt: 1'b0, has_prv: l_ent.occ};
        l_we    = 1'b1;
        l_waddr = {side_r, px_r};
        l_wr    = '{occ: 1'b1, head: (l_ent.occ ? l_ent.head : id_r), tail: id_r};
        valid_nxt[id_r] = 1'b1;
        if (side_r) begin
          if (!ask_ok_r || (px_r < ask_px_r)) begin
            ask_ok_nxt = 1'b1;
            ask_px_nxt = px_r;
          end
        end else begin
          if (!bid_ok_r || (px_r > bid_px_r)) begin
            bid_ok_nxt = 1'b1;
            bid_px_nxt = px_r;
          end
        end
        if (l_ent.occ) begin
          head_nxt  = l_ent.tail;
          o_re      = 1'b1;
          o_raddr   = l_ent.tail;
          state_nxt = S_R_TL;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_R_TL: begin
        o_we       = 1'b1;
        o_waddr    = head_r;
        o_wr       = o_ent;
        o_wr.nxt   = id_r;
        o_wr.has_nxt = 1'b1;
        state_nxt  = S_DONE;
      end

      S_UL_RD: begin
        l_re      = 1'b1;
        l_raddr   = {ent_r.side, ent_r.px};
        valid_nxt[ul_id_r] = 1'b0;
        state_nxt = S_UL_LV;
      end

      S_UL_LV: begin
        l_we    = 1'b1;
        l_waddr = {ent_r.side, ent_r.px};
        l_wr    = l_ent;
        if (!ent_r.has_prv) begin
          l_wr.head = ent_r.nxt;
        end
        if (!ent_r.has_nxt) begin
          l_wr.tail = ent_r.prv;
        end
        if (!ent_r.has_prv && !ent_r.has_nxt) begin
          l_wr.occ = 1'b0;
        end
        empt_nxt = !ent_r.has_prv && !ent_r.has_nxt;
        if (ent_r.has_prv) begin
          o_re      = 1'b1;
          o_raddr   = ent_r.prv;
          state_nxt = S_UL_PV;
        end else if (ent_r.has_nxt) begin
          o_re      = 1'b1;
          o_raddr   = ent_r.nxt;
          state_nxt = S_UL_NX;
        end else begin
          state_nxt = S_UL_FIN;
        end
      end

      S_UL_PV: begin
        o_we         = 1'b1;
        o_waddr      = ent_r.prv;
        o_wr         = o_ent;
        o_wr.nxt     = ent_r.nxt;
        o_wr.has_nxt = ent_r.has_nxt;
        if (ent_r.has_nxt) begin
          o_re      = 1'b1;
          o_raddr   = ent_r.nxt;
          state_nxt = S_UL_NX;
        end else begin
          state_nxt = S_UL_FIN;
        end
      end

      S_UL_NX: begin
        o_we         = 1'b1;
        o_waddr      = ent_r.nxt;
        o_wr         = o_ent;
        o_wr.prv     = ent_r.prv;
        o_wr.has_prv = ent_r.has_prv;
        state_nxt    = S_UL_FIN;
      end

      S_UL_FIN: begin
        if (empt_r && was_best) begin
          sc_k_nxt     = '0;
          sc_pend_nxt  = 1'b0;
          sc_found_nxt = 1'b0;
          sc_px_nxt    = '0;
          sc_side_nxt  = ent_r.side;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = (cmd_r == CMD_CANCEL) ? S_DONE : S_ADD;
        end
      end

      S_SCAN: begin
        if (sc_pend_r && scan_hit) begin
          sc_found_nxt = 1'b1;
          sc_px_nxt    = o_ent.px;
        end
        if (sc_k_r < CNT_W'(ORDER_SLOTS)) begin
          o_re        = 1'b1;
          o_raddr     = sc_k_r[ID_W-1:0];
          sc_idx_nxt  = sc_k_r[ID_W-1:0];
          sc_k_nxt    = sc_k_r + 1'b1;
          sc_pend_nxt = 1'b1;
        end else begin
          sc_pend_nxt = 1'b0;
          if (!sc_pend_r) begin
            if (sc_side_r) begin
              ask_ok_nxt = sc_found_r;
              ask_px_nxt = sc_found_r ? sc_px_r : '0;
            end else begin
              bid_ok_nxt = sc_found_r;
              bid_px_nxt = sc_found_r ? sc_px_r : '0;
            end
            state_nxt = (cmd_r == CMD_CANCEL) ? S_DONE : S_ADD;
          end
        end
      end

      S_DONE: begin
        em_k_nxt    = '0;
        em_pend_nxt = 1'b0;
        state_nxt   = (nfill_r == '0) ? S_STAT : S_EMIT;
      end

      S_EMIT: begin
        if (em_k_r < nfill_r) begin
          f_re        = 1'b1;
          f_raddr     = em_k_r[ID_W-1:0];
          em_k_nxt    = em_k_r + 1'b1;
          em_pend_nxt = 1'b1;
        end else begin
          em_pend_nxt = 1'b0;
        end
        if (em_pend_r && (em_k_r == nfill_r)) begin
          state_nxt = S_IDLE;
        end
      end

      S_STAT: begin
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLR;
      clr_r     <= '0;
      valid_r   <= '0;
      bid_ok_r  <= 1'b0;
      bid_px_r  <= '0;
      ask_ok_r  <= 1'b0;
      ask_px_r  <= '0;
      nfill_r   <= '0;
      sc_k_r    <= '0;
      sc_pend_r <= 1'b0;
      em_k_r    <= '0;
      em_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      valid_r   <= valid_nxt;
      bid_ok_r  <= bid_ok_nxt;
      bid_px_r  <= bid_px_nxt;
      ask_ok_r  <= ask_ok_nxt;
      ask_px_r  <= ask_px_nxt;
      nfill_r   <= nfill_nxt;
      sc_k_r    <= sc_k_nxt;
      sc_pend_r <= sc_pend_nxt;
      em_k_r    <= em_k_nxt;
      em_pend_r <= em_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    side_r     <= side_nxt;
    px_r       <= px_nxt;
    qty_r      <= qty_nxt;
    status_r   <= status_nxt;
    ent_r      <= ent_nxt;
    ul_id_r    <= ul_id_nxt;
    head_r     <= head_nxt;
    empt_r     <= empt_nxt;
    sc_idx_r   <= sc_idx_nxt;
    sc_found_r <= sc_found_nxt;
    sc_px_r    <= sc_px_nxt;
    sc_side_r  <= sc_side_nxt;
  end

  lobm_ram #(.WIDTH(ORD_W), .DEPTH(ORDER_SLOTS)) u_ord_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wr),
    .re    (o_re),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  lobm_ram #(.WIDTH(LVL_W), .DEPTH(LVL_DEPTH)) u_lvl_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wr),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  lobm_ram #(.WIDTH(FILL_W), .DEPTH(ORDER_SLOTS)) u_fill_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wr),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // Result beats: fills during playout, a single status beat otherwise.
  logic is_fill;
  assign is_fill = (state_r == S_EMIT) && em_pend_r;

  assign busy            = (state_r != S_IDLE);
  assign out_strobe      = is_fill || (state_r == S_STAT);
  assign out_is_trade    = is_fill;
  assign out_taker_id    = is_fill ? 6'(id_r) : 6'd0;
  assign out_maker_id    = is_fill ? 6'(f_ent.maker) : 6'd0;
  assign out_trade_price = is_fill ? 8'(f_ent.px) : 8'd0;
  assign out_fill_qty    = is_fill ? 16'(f_ent.qty) : 16'd0;
  assign out_taker_side  = is_fill ? side_r : 1'b0;
  assign out_status      = (state_r == S_STAT) ? status_r : ST_OK;
  assign out_last        = (state_r == S_STAT) || (is_fill && (em_k_r == nfill_r));
  assign out_bid_valid   = bid_ok_r;
  assign out_bid_price   = bid_ok_r ? 8'(bid_px_r) : 8'd0;
  assign out_ask_valid   = ask_ok_r;
  assign out_ask_price   = ask_ok_r ? 8'(ask_px_r) : 8'd0;

endmodule

// ===== design/lobm_chk.sv =====
// ============================================================================
// Limit order book matcher checker
// Port-level properties of the matcher's command and result beats.
// ============================================================================
`include "limit_order_book_matcher_unit_defines.svh"

module lobm_chk
  import lobm_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_strobe,
  input logic       out_is_trade,
  input logic [1:0] out_status,
  input logic       out_last
);

  // A fill never carries an error status.
  `LOBM_ASSERT_NOW(a_fill_ok, clk, rst_n, out_strobe && out_is_trade, out_status == ST_OK, "fill with status")
  // A status beat is always the only and final beat of its command.
  `LOBM_ASSERT_NOW(a_stat_last, clk, rst_n, out_strobe && !out_is_trade, out_last, "status beat not last")
  // Results only appear while a command is in progress.
  `LOBM_ASSERT_NOW(a_strobe_busy, clk, rst_n, out_strobe, busy, "result while idle")
  // Nothing follows the final beat of a command.
  `LOBM_ASSERT_NEXT(a_last_quiet, clk, rst_n, out_strobe && out_last, !out_strobe, "beat after last")
  // A taken command keeps the unit busy in the next cycle.
  `LOBM_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy, "not busy after start")

endmodule

bind limit_order_book_matcher_unit lobm_chk u_lobm_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_strobe   (out_strobe),
  .out_is_trade (out_is_trade),
  .out_status   (out_status),
  .out_last     (out_last)
);
